// ===== src/sprite_blit_color_key_macros.svh =====
// assertion helpers for the blitter back end
// each expects clk and rst_n in scope
`ifndef SPRITE_BLIT_COLOR_KEY_MACROS_SVH
`define SPRITE_BLIT_COLOR_KEY_MACROS_SVH

// same-cycle implication
`define SBCK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbck assertion failed");

// next-cycle implication
`define SBCK_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbck assertion failed");

`endif

// ===== src/sbck_pkg.sv =====
package sbck_pkg;

  localparam int PIXEL_W   = 32;
  localparam int POS_W     = 11;
  localparam int DIM_REG_W = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int BYTES_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic [DIM_REG_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [DIM_REG_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [DIM_REG_W-1:0] RST_SPRITE_WIDTH  = 12'd1;
  localparam logic [DIM_REG_W-1:0] RST_SPRITE_HEIGHT = 12'd1;

  typedef enum logic [2:0] {
    MODE_8BPP  = 3'd0,
    MODE_15BPP = 3'd1,
    MODE_16BPP = 3'd2,
    MODE_24BPP = 3'd3,
    MODE_32BPP = 3'd4
  } pixel_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE    = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_PAGE_SELECT   = 3'd3,
    CFG_DEST_X        = 3'd4,
    CFG_DEST_Y        = 3'd5,
    CFG_SPRITE_WIDTH  = 3'd6,
    CFG_SPRITE_HEIGHT = 3'd7
  } cfg_index_t;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [POS_W-1:0]   col;
    logic               first;
    logic               row_end;
    logic               sprite_end;
    logic               off_screen;
  } sbck_item_t;

  // bytes per pixel, undefined modes write one byte
  function automatic logic [BYTES_W-1:0] mode_bytes(input pixel_mode_t mode);
    unique case (mode)
      MODE_8BPP:  return 3'd1;
      MODE_15BPP: return 3'd2;
      MODE_16BPP: return 3'd2;
      MODE_24BPP: return 3'd3;
      MODE_32BPP: return 3'd4;
      default:    return 3'd1;
    endcase
  endfunction

  // bits tested for transparency, none for undefined modes
  function automatic logic [PIXEL_W-1:0] mode_key_mask(input pixel_mode_t mode);
    unique case (mode)
      MODE_8BPP:  return 32'h0000_00FF;
      MODE_15BPP: return 32'h0000_7FFF;
      MODE_16BPP: return 32'h0000_FFFF;
      MODE_24BPP: return 32'h00FF_FFFF;
      MODE_32BPP: return 32'hFFFF_FFFF;
      default:    return 32'h0000_0000;
    endcase
  endfunction

  // bits carried in the write data
  function automatic logic [PIXEL_W-1:0] mode_data_mask(input pixel_mode_t mode);
    unique case (mode)
      MODE_8BPP:  return 32'h0000_00FF;
      MODE_15BPP: return 32'h0000_FFFF;
      MODE_16BPP: return 32'h0000_FFFF;
      MODE_24BPP: return 32'h00FF_FFFF;
      MODE_32BPP: return 32'hFFFF_FFFF;
      default:    return 32'h0000_0000;
    endcase
  endfunction

endpackage

// ===== src/sbck_front.sv =====
module sbck_front
  import sbck_pkg::*;
#(
  parameter int MAX_DIM = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PIXEL_W-1:0]                  in_pixel,
  input  logic [$clog2(MAX_DIM+1)-1:0]        sw,
  input  logic [$clog2(MAX_DIM+1)-1:0]        sh,
  input  logic [$clog2(MAX_DIM+1)-1:0]        spw,
  input  logic [$clog2(MAX_DIM+1)-1:0]        sph,
  input  logic [POS_W-1:0]                    dest_x,
  input  logic [POS_W-1:0]                    dest_y,
  output logic                                q_valid,
  input  logic                                q_ready,
  output sbck_item_t                          q_item
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > POS_W + 1) ? DIM_W : POS_W + 1;

  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CMP_W-1:0] col_inc, row_inc, scr_x, scr_y;
  logic             accept, row_end, sprite_end, off_screen;

  // words pass straight into the queue
  assign q_valid  = in_valid;
  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // row and sprite end, screen bounds
  always_comb begin
    col_inc    = CMP_W'(col_r) + CMP_W'(1);
    row_inc    = CMP_W'(row_r) + CMP_W'(1);
    scr_x      = CMP_W'(dest_x) + CMP_W'(col_r);
    scr_y      = CMP_W'(dest_y) + CMP_W'(row_r);
    row_end    = col_inc >= CMP_W'(spw);
    sprite_end = row_end && (row_inc >= CMP_W'(sph));
    off_screen = (scr_x >= CMP_W'(sw)) || (scr_y >= CMP_W'(sh));
  end

  // classified word
  always_comb begin
    q_item.pixel      = in_pixel;
    q_item.col        = col_r;
    q_item.first      = (col_r == '0) && (row_r == '0);
    q_item.row_end    = row_end;
    q_item.sprite_end = sprite_end;
    q_item.off_screen = off_screen;
  end

  // column and row counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (sprite_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/sbck_queue.sv =====
module sbck_queue
  import sbck_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  sbck_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output sbck_item_t rd_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sbck_item_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign wr_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== src/sbck_back.sv =====
`include "sprite_blit_color_key_macros.svh"

module sbck_back
  import sbck_pkg::*;
#(
  parameter int MAX_DIM      = 2048,
  parameter int ADDRESS_BITS = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  sbck_item_t                   q_item,
  input  pixel_mode_t                  pixel_mode,
  input  logic                         page_select,
  input  logic [$clog2(MAX_DIM+1)-1:0] sw,
  input  logic [$clog2(MAX_DIM+1)-1:0] sh,
  input  logic [POS_W-1:0]             dest_x,
  input  logic [POS_W-1:0]             dest_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_write_enable,
  output logic [ADDRESS_BITS-1:0]      out_byte_address,
  output logic [PIXEL_W-1:0]           out_write_data,
  output logic [BYTES_W-1:0]           out_byte_count,
  output logic                         out_off_screen,
  output logic                         out_last
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int AB    = ADDRESS_BITS;
  localparam int SB_W  = (POS_W + DIM_W + 1 > AB) ? POS_W + DIM_W + 1 : AB;
  localparam int AW    = (2 * DIM_W > AB) ? 2 * DIM_W : AB;

  // multiply by bytes per pixel with shifts and at most one add
  function automatic logic [AB-1:0] scale_bytes(input logic [AB-1:0] v,
                                                input logic [BYTES_W-1:0] n);
    case (n)
      3'd2:    return v << 1;
      3'd3:    return v + (v << 1);
      3'd4:    return v << 2;
      default: return v;
    endcase
  endfunction

  logic [SB_W-1:0]    start_full;
  logic [AW-1:0]      area_full;
  logic [AB-1:0]      start_base_r, area_r, page_r;
  logic [BYTES_W-1:0] bytes;

  logic               b1_valid_r;
  logic [AB-1:0]      b1_idx_r;
  logic [BYTES_W-1:0] b1_bytes_r;
  logic               b1_opaque_r, b1_off_r, b1_last_r;
  logic [PIXEL_W-1:0] b1_data_r;

  logic [AB-1:0]      base_r, base_nxt, row_base, idx;
  logic               pop, b1_adv, out_adv;

  logic               out_valid_r, out_we_r, out_off_r, out_last_r;
  logic [AB-1:0]      out_addr_r;
  logic [PIXEL_W-1:0] out_data_r;
  logic [BYTES_W-1:0] out_bytes_r;

  assign bytes = mode_bytes(pixel_mode);

  // sprite origin and page offset from configuration
  assign start_full = SB_W'(dest_y) * SB_W'(sw) + SB_W'(dest_x);
  assign area_full  = AW'(sw) * AW'(sh);

  always_ff @(posedge clk) begin
    start_base_r <= start_full[AB-1:0];
    area_r       <= area_full[AB-1:0];
    page_r       <= page_select ? scale_bytes(area_r, bytes) : '0;
  end

  // stage handshake
  assign out_adv = !out_valid_r || out_ready;
  assign b1_adv  = !b1_valid_r || out_adv;
  assign q_ready = b1_adv;
  assign pop     = q_valid && b1_adv;

  // row base tracking and pixel index
  always_comb begin
    row_base = q_item.first ? start_base_r : base_r;
    idx      = row_base + AB'(q_item.col);
    base_nxt = row_base;
    if (q_item.row_end && !q_item.sprite_end) begin
      base_nxt = row_base + AB'(sw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (pop) begin
      base_r <= base_nxt;
    end
  end

  // stage one: index, key test, data mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (b1_adv) begin
      b1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_idx_r    <= idx;
      b1_bytes_r  <= bytes;
      b1_opaque_r <= (q_item.pixel & mode_key_mask(pixel_mode)) != '0;
      b1_data_r   <= q_item.pixel & mode_data_mask(pixel_mode);
      b1_off_r    <= q_item.off_screen;
      b1_last_r   <= q_item.sprite_end;
    end
  end

  // output register: byte address and the other write fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && b1_valid_r) begin
      out_we_r    <= b1_opaque_r;
      out_addr_r  <= scale_bytes(b1_idx_r, b1_bytes_r) + page_r;
      out_data_r  <= b1_data_r;
      out_bytes_r <= b1_bytes_r;
      out_off_r   <= b1_off_r;
      out_last_r  <= b1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_byte_address = out_addr_r;
  assign out_write_data   = out_data_r;
  assign out_byte_count   = out_bytes_r;
  assign out_off_screen   = out_off_r;
  assign out_last         = out_last_r;

  // checks
  `SBCK_ASSERT_IMP(a_we_nonzero_data, out_valid_r && out_we_r, out_data_r != '0)
  `SBCK_ASSERT_IMP(a_byte_count_range, out_valid_r,
                   out_bytes_r != 3'd0 && out_bytes_r <= 3'd4)
  `SBCK_ASSERT_IMP(a_data_fits_count, out_valid_r && out_bytes_r != 3'd4,
                   out_data_r[31:24] == 8'd0)
  `SBCK_ASSERT_NXT(a_stage_one_holds, b1_valid_r && !out_adv,
                   b1_valid_r && $stable(b1_idx_r) && $stable(b1_last_r))

endmodule

// ===== src/sprite_blit_color_key.sv =====
// Color-key sprite blitter.
// Input channel in_valid/in_ready/in_pixel takes sprite pixels in row-major
// order; the result channel out_* gives one framebuffer write word per pixel
// (enable, byte address, data, byte count, off-screen flag, last-of-sprite).
// A zero pixel under the mode's key mask comes out with write enable low.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata,
// one register per cycle; the user must write them only while no word is
// in flight; the block does not enforce this. A word passes through the
// queue, the index stage and the address register. Throughput: one word
// per cycle while out_ready is high; the column/row counters and the running
// row base advance by increments, so no pixel waits on another.
// A two-entry queue sits between the classifying front end and the address
// pipeline; when out_ready is low the pipeline holds its words and the
// queue fills, after which in_ready drops. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) restores register defaults (8bpp, 640x480,
// page 0, origin 0, 1x1 sprite), clears the counters and empties the pipe.
module sprite_blit_color_key
  import sbck_pkg::*;
#(
  parameter int MAX_DIM      = 2048,
  parameter int ADDRESS_BITS = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_W-1:0]      in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_write_enable,
  output logic [ADDRESS_BITS-1:0] out_byte_address,
  output logic [PIXEL_W-1:0]      out_write_data,
  output logic [BYTES_W-1:0]      out_byte_count,
  output logic                    out_off_screen,
  output logic                    out_last
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;

  // saturate a dimension register to one through MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) begin
      return DIM_W'(1);
    end else if (ve > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return ve[DIM_W-1:0];
    end
  endfunction

  pixel_mode_t          pixel_mode_r;
  logic [DIM_REG_W-1:0] screen_width_r, screen_height_r;
  logic [DIM_REG_W-1:0] sprite_width_r, sprite_height_r;
  logic                 page_select_r;
  logic [POS_W-1:0]     dest_x_r, dest_y_r;
  logic [DIM_W-1:0]     sw, sh, spw, sph;

  logic                 q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  sbck_item_t           q_wr_item, q_rd_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r    <= MODE_8BPP;
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      page_select_r   <= 1'b0;
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      sprite_width_r  <= RST_SPRITE_WIDTH;
      sprite_height_r <= RST_SPRITE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PIXEL_MODE:    pixel_mode_r    <= pixel_mode_t'(cfg_wdata[2:0]);
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        CFG_PAGE_SELECT:   page_select_r   <= cfg_wdata[0];
        CFG_DEST_X:        dest_x_r        <= cfg_wdata[POS_W-1:0];
        CFG_DEST_Y:        dest_y_r        <= cfg_wdata[POS_W-1:0];
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata;
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // saturated dimensions
  assign sw  = clamp_dim(screen_width_r);
  assign sh  = clamp_dim(screen_height_r);
  assign spw = clamp_dim(sprite_width_r);
  assign sph = clamp_dim(sprite_height_r);

  sbck_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .sw       (sw),
    .sh       (sh),
    .spw      (spw),
    .sph      (sph),
    .dest_x   (dest_x_r),
    .dest_y   (dest_y_r),
    .q_valid  (q_wr_valid),
    .q_ready  (q_wr_ready),
    .q_item   (q_wr_item)
  );

  sbck_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  sbck_back #(
    .MAX_DIM      (MAX_DIM),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_rd_valid),
    .q_ready          (q_rd_ready),
    .q_item           (q_rd_item),
    .pixel_mode       (pixel_mode_r),
    .page_select      (page_select_r),
    .sw               (sw),
    .sh               (sh),
    .dest_x           (dest_x_r),
    .dest_y           (dest_y_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_byte_address (out_byte_address),
    .out_write_data   (out_write_data),
    .out_byte_count   (out_byte_count),
    .out_off_screen   (out_off_screen),
    .out_last         (out_last)
  );

endmodule
